// File: rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is held.
`define FE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication form of the same check.
`define FE_ASSERT_IMP(label, ante, cons, msg) \
    `FE_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: rtl/fade_env_pkg.sv
// -----------------------------------------------------------------------------
// fade_env_pkg
// Shared constants for the fade-in / hold / fade-out envelope.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fade_env_pkg;

    // Default parameter values.
    localparam int ALPHA_FRAC_BITS_DEF = 12;
    localparam int TIMER_BITS_DEF      = 18;

    // Fixed field widths.
    localparam int DUR_W     = 16;
    localparam int ELAPSED_W = 12;
    localparam int CFG_IDX_W = 2;

    // Phase codes.
    localparam logic [1:0] PH_HIDDEN   = 2'd0;
    localparam logic [1:0] PH_FADE_IN  = 2'd1;
    localparam logic [1:0] PH_HOLD     = 2'd2;
    localparam logic [1:0] PH_FADE_OUT = 2'd3;

    // Input item kinds.
    localparam logic MODE_TICK     = 1'b0;
    localparam logic MODE_ACTIVATE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT_TIME = 2'd2;

    // Register reset values.
    localparam logic [DUR_W-1:0] FADE_IN_TIME_RST  = 16'd500;
    localparam logic [DUR_W-1:0] HOLD_TIME_RST     = 16'd2000;
    localparam logic [DUR_W-1:0] FADE_OUT_TIME_RST = 16'd1000;

endpackage

`default_nettype wire

// File: rtl/fade_in_hold_fade_out_envelope.sv
// -----------------------------------------------------------------------------
// fade_in_hold_fade_out_envelope
// Four-phase intensity envelope (hidden, fade-in, hold, fade-out) in unsigned Q1.F.
// -----------------------------------------------------------------------------
// Each request on the slave stream is either a tick (tuser = 0, tdata carries
// the milliseconds since the previous tick) or an activate request (tuser = 1).
// Every request yields exactly one result carrying the alpha level and the
// phase after the step, plus a drawn flag. Activate requests, hidden ticks,
// hold ticks, ticks that change phase and ticks of a zero-length fade finish in
// the cycle they are taken. A tick inside a fade computes the ramp with a shared
// restoring divider that produces one quotient bit per cycle, so its result is
// presented only once the divider is done, and no new request is taken until
// then. The block works on one request at a time: tready drops while the divider
// runs and while a finished result is still waiting on the master side. The timer
// saturates at 2^TIMER_BITS - 1. Configuration writes are always accepted and
// should only be issued while no request is in flight.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fade_in_hold_fade_out_envelope
    import fade_env_pkg::*;
#(
    parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF,
    parameter int TIMER_BITS      = TIMER_BITS_DEF,
    localparam int OUT_TDATA_W    = ((ALPHA_FRAC_BITS + 3 + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration write channel.
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [DUR_W-1:0]       i_cfg_data,
    // Slave stream.
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [15:0]            i_s_tdata,   // [11:0] elapsed_ms, [15:12] zero
    input  wire logic                   i_s_tuser,   // [0] mode
    // Master stream.
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // alpha_out, then phase_out, zero fill
    output logic                        o_m_tuser    // [0] drawn
);

    localparam int AW = ALPHA_FRAC_BITS + 1;
    localparam logic [AW-1:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    // Sequencer states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    // Configuration registers.
    logic [DUR_W-1:0] r_fade_in_time, r_hold_time, r_fade_out_time;

    // Envelope state.
    logic                  r_state, n_state;
    logic [1:0]            r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [AW-1:0]         r_alpha, n_alpha;
    logic [ELAPSED_W-1:0]  r_dt, n_dt;

    // Result register.
    logic          r_out_valid, n_out_valid;
    logic          r_out_drawn, n_out_drawn;
    logic [AW-1:0] r_out_alpha, n_out_alpha;
    logic [1:0]    r_out_phase, n_out_phase;

    // Divider interface.
    logic             div_start;
    logic [DUR_W-1:0] div_den;
    logic             div_done;
    logic [AW-1:0]    div_quo;

    logic                  accept;
    logic                  in_mode;
    logic [ELAPSED_W-1:0]  in_dt;
    logic [ELAPSED_W-1:0]  dt_sel;
    logic [TIMER_BITS:0]   timer_sum;
    logic [TIMER_BITS-1:0] timer_adv;
    logic [TIMER_BITS-1:0] timer_fresh;
    logic [AW+DUR_W-1:0]   resume_prod;
    logic [TIMER_BITS-1:0] resume_timer;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_in_time  <= FADE_IN_TIME_RST;
            r_hold_time     <= HOLD_TIME_RST;
            r_fade_out_time <= FADE_OUT_TIME_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FADE_IN_TIME:  r_fade_in_time  <= i_cfg_data;
                CFG_HOLD_TIME:     r_hold_time     <= i_cfg_data;
                CFG_FADE_OUT_TIME: r_fade_out_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A new request is taken only when the sequencer is idle and the result slot is free or draining.
    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_mode    = i_s_tuser;
    assign in_dt      = i_s_tdata[ELAPSED_W-1:0];

    // Saturating timer advance, shared by the accept cycle and the divider finish.
    assign dt_sel      = (r_state == ST_DIV) ? r_dt : in_dt;
    assign timer_sum   = {1'b0, r_timer} + (TIMER_BITS+1)'(dt_sel);
    assign timer_adv   = timer_sum[TIMER_BITS] ? TIMER_MAX : timer_sum[TIMER_BITS-1:0];
    assign timer_fresh = TIMER_BITS'(in_dt);

    // Re-entry point of a fade-in that interrupts a fade-out.
    assign resume_prod  = r_alpha * r_fade_in_time;
    assign resume_timer = TIMER_BITS'(resume_prod[AW+DUR_W-1:ALPHA_FRAC_BITS]);

    assign div_den = (r_phase == PH_FADE_OUT) ? r_fade_out_time : r_fade_in_time;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_alpha     = r_alpha;
        n_dt        = r_dt;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_drawn = r_out_drawn;
        n_out_alpha = r_out_alpha;
        n_out_phase = r_out_phase;
        div_start   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_drawn = 1'b0;
                    if (in_mode == MODE_ACTIVATE) begin
                        unique case (r_phase)
                            PH_HIDDEN:   n_phase = PH_FADE_IN;
                            PH_HOLD:     n_timer = '0;
                            PH_FADE_OUT: begin
                                n_phase = PH_FADE_IN;
                                n_timer = resume_timer;
                            end
                            default: ;
                        endcase
                    end else begin
                        unique case (r_phase)
                            PH_FADE_IN: begin
                                n_out_drawn = 1'b1;
                                if (r_timer > TIMER_BITS'(r_fade_in_time)) begin
                                    n_phase = PH_HOLD;
                                    n_alpha = ALPHA_ONE;
                                    n_timer = timer_fresh;
                                end else if (r_fade_in_time == '0) begin
                                    // Zero-length fade with a zero timer is full at once.
                                    n_alpha = ALPHA_ONE;
                                    n_timer = timer_adv;
                                end else begin
                                    div_start = 1'b1;
                                end
                            end
                            PH_HOLD: begin
                                n_out_drawn = 1'b1;
                                if (r_timer > TIMER_BITS'(r_hold_time)) begin
                                    n_phase = PH_FADE_OUT;
                                    n_alpha = ALPHA_ONE;
                                    n_timer = timer_fresh;
                                end else begin
                                    n_timer = timer_adv;
                                end
                            end
                            PH_FADE_OUT: begin
                                if (r_timer > TIMER_BITS'(r_fade_out_time)) begin
                                    n_phase = PH_HIDDEN;
                                    n_alpha = '0;
                                    n_timer = timer_fresh;
                                end else if (r_fade_out_time == '0) begin
                                    n_out_drawn = 1'b1;
                                    n_alpha     = '0;
                                    n_timer     = timer_adv;
                                end else begin
                                    n_out_drawn = 1'b1;
                                    div_start   = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (div_start) begin
                        n_state = ST_DIV;
                        n_dt    = in_dt;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_alpha = n_alpha;
                        n_out_phase = n_phase;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_alpha     = (r_phase == PH_FADE_OUT) ? (ALPHA_ONE - div_quo) : div_quo;
                    n_timer     = timer_adv;
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_alpha = n_alpha;
                    n_out_phase = r_phase;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_HIDDEN;
            r_timer     <= '0;
            r_alpha     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_timer     <= n_timer;
            r_alpha     <= n_alpha;
            r_out_valid <= n_out_valid;
        end
        r_dt        <= n_dt;
        r_out_drawn <= n_out_drawn;
        r_out_alpha <= n_out_alpha;
        r_out_phase <= n_out_phase;
    end

    // The timer never exceeds the fade length while a ramp is computed, so its
    // low bits are the whole numerator.
    fade_env_div #(
        .FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_timer[DUR_W-1:0]),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_phase, r_out_alpha});
    assign o_m_tuser  = r_out_drawn;

endmodule

`default_nettype wire

// File: rtl/fade_env_div.sv
// -----------------------------------------------------------------------------
// fade_env_div
// Restoring divider that forms floor(num * 2^FRAC_BITS / den) for num <= den.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fade_env_div
    import fade_env_pkg::*;
#(
    parameter int FRAC_BITS = ALPHA_FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DUR_W-1:0]     i_num,
    input  wire logic [DUR_W-1:0]     i_den,
    output logic                      o_done,
    output logic [FRAC_BITS:0]        o_quo
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DUR_W:0]   r_rem, n_rem;
    logic [DUR_W-1:0] r_den, n_den;
    logic [FRAC_BITS:0] r_quo, n_quo;

    logic           ge;
    logic [DUR_W:0] rem_sel;

    // One quotient bit per cycle; the remainder stays below twice the divisor.
    always_comb begin
        ge      = r_rem >= {1'b0, r_den};
        rem_sel = ge ? (r_rem - {1'b0, r_den}) : r_rem;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_quo   = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(FRAC_BITS);
            n_rem  = {1'b0, i_num};
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = {rem_sel[DUR_W-1:0], 1'b0};
            n_quo = {r_quo[FRAC_BITS-1:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// File: rtl/fade_env_chk.sv
// -----------------------------------------------------------------------------
// fade_env_chk
// Port-level checks for the envelope, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fade_env_chk
    import fade_env_pkg::*;
#(
    parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF,
    localparam int OUT_TDATA_W    = ((ALPHA_FRAC_BITS + 3 + 7) / 8) * 8
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_s_tready,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                   o_m_tuser
);

    localparam int AW = ALPHA_FRAC_BITS + 1;
    localparam logic [AW-1:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};

    logic [AW-1:0] alpha;
    logic [1:0]    phase;

    assign alpha = o_m_tdata[AW-1:0];
    assign phase = o_m_tdata[AW+1:AW];

    `FE_ASSERT_IMP(a_out_held, o_m_tvalid && !i_m_tready, ##1 o_m_tvalid, "result dropped while stalled")
    `FE_ASSERT_IMP(a_no_take_when_full, o_m_tvalid && !i_m_tready, !o_s_tready, "request taken while result slot is full")
    `FE_ASSERT_IMP(a_hidden_not_drawn, o_m_tvalid && (phase == PH_HIDDEN), !o_m_tuser, "hidden result marked drawn")
    `FE_ASSERT_IMP(a_alpha_range, o_m_tvalid, alpha <= ALPHA_ONE, "alpha above full scale")
    `FE_ASSERT_IMP(a_hold_full, o_m_tvalid && (phase == PH_HOLD), alpha == ALPHA_ONE, "hold phase without full alpha")

endmodule

bind fade_in_hold_fade_out_envelope fade_env_chk #(
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
) u_fade_env_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
